/* design/olad_pkg.sv */
// Package for the ordered list core: field widths, opcodes, status codes,
// command kinds, the queue word and the back end state type. No dependencies.
`timescale 1ns / 1ps

package olad_pkg;

  localparam int OP_W        = 2;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 4;
  localparam int STATUS_W    = 3;
  localparam int LEN_W       = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_RANGE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_DELETE,
    KIND_READ,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } olad_cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_MATCH
  } back_state_t;

endpackage

/* design/olad_front.sv */
// Front end of the ordered list core: accepts input words, decodes the
// opcode into a command kind and holds commands in a short queue. Uses olad_pkg.
`timescale 1ns / 1ps

module olad_front import olad_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    q_valid,
  input  logic                    q_ready,
  output olad_cmd_t               q_cmd
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  olad_cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_r;
  logic [QPTR_W-1:0]      rd_ptr_r;
  logic [QCNT_W-1:0]      fill_r;
  olad_cmd_t              cmd_in;
  logic                   push;
  logic                   pop;

  always_comb begin
    cmd_in.value    = in_value;
    cmd_in.position = in_position;
    case (in_opcode)
      OP_APPEND: cmd_in.kind = KIND_APPEND;
      OP_DELETE: cmd_in.kind = KIND_DELETE;
      OP_READ:   cmd_in.kind = KIND_READ;
      default:   cmd_in.kind = KIND_NOP;
    endcase
  end

  assign in_ready = (fill_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_cmd    = q_mem[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

/* design/olad_back.sv */
// Back end of the ordered list core: the row of list cells, the match and
// shift logic, the count and the registered result word. Uses olad_pkg.
`timescale 1ns / 1ps

module olad_back import olad_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  olad_cmd_t               q_cmd,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [LEN_W-1:0]        out_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  back_state_t             state_r;
  back_state_t             state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic signed [VAL_W-1:0] cells_r [CAPACITY];
  logic [CAPACITY-1:0]     match_now;
  logic [CAPACITY-1:0]     match_r;
  logic [CAPACITY-1:0]     hit_mask;
  logic signed [VAL_W-1:0] rd_mux;
  logic                    out_free;
  logic                    need_match;
  logic                    done;
  logic                    app_we;
  logic                    del_shift;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_rd;
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic signed [VAL_W-1:0] out_read_value_r;
  logic [LEN_W-1:0]        out_length_r;

  assign out_free   = !out_valid_r || out_ready;
  assign need_match = q_valid && (q_cmd.kind == KIND_DELETE) && (count_r != '0);
  assign hit_mask   = match_r | (~match_r + 1'b1);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_now[i] = (cells_r[i] == q_cmd.value) && (i < int'(count_r));
    end
  end

  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == int'(q_cmd.position)) begin
        rd_mux = cells_r[i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (need_match) begin
          state_nxt = BK_MATCH;
        end
      end
      BK_MATCH: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready    = 1'b0;
    done       = 1'b0;
    app_we     = 1'b0;
    del_shift  = 1'b0;
    res_status = STAT_OK;
    res_rd     = '0;
    count_nxt  = count_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && !need_match && out_free) begin
          done    = 1'b1;
          q_ready = 1'b1;
          case (q_cmd.kind)
            KIND_APPEND: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status = STAT_FULL;
              end else begin
                app_we    = 1'b1;
                count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
            KIND_DELETE: res_status = STAT_EMPTY;
            KIND_READ: begin
              if (int'(q_cmd.position) >= int'(count_r)) begin
                res_status = STAT_RANGE;
              end else begin
                res_rd = rd_mux;
              end
            end
            default: res_status = STAT_OK;
          endcase
        end
      end
      BK_MATCH: begin
        if (out_free) begin
          done    = 1'b1;
          q_ready = 1'b1;
          if (match_r == '0) begin
            res_status = STAT_NOTFOUND;
          end else begin
            del_shift = 1'b1;
            count_nxt = CNT_W'(count_r - 1'b1);
          end
        end
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] shift_in;
    if (g < CAPACITY - 1) begin : g_mid
      assign shift_in = cells_r[g+1];
    end else begin : g_last
      assign shift_in = cells_r[g];
    end
    always_ff @(posedge clk) begin
      if (app_we && (g == int'(count_r))) begin
        cells_r[g] <= q_cmd.value;
      end else if (del_shift && hit_mask[g]) begin
        cells_r[g] <= shift_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE) begin
      match_r <= match_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r     <= res_status;
      out_read_value_r <= res_rd;
      out_length_r     <= LEN_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_length     = out_length_r;

endmodule

/* design/ordered_list_append_delete_core.sv */
// Top level of the ordered list core: a front end with a command queue
// feeding a back end that holds the list cells. Uses olad_pkg, olad_front, olad_back.
//
// Each input word carries an opcode (append, delete first match, read at
// position), a value and a position. Every accepted word yields exactly one
// result word with a status, the value read and the list length afterward.
// Both channels use valid and ready; results come out in input order.
// Append, read and unused opcodes pass the queue, then the result register;
// the back end can finish one per cycle while the result register is free.
// A delete on a non-empty list compares all cells against the value in the
// idle state, registers the matches and closes the gap by shifting in BK_MATCH.
// The two-entry command queue lets the input side keep accepting while the
// back end works or while a result waits. When the receiver stalls, the result
// register holds its word and the back end stops; the queue then fills and
// in_ready drops. Reset empties the queue and the list; cell contents are
// not cleared, since only cells below the length are ever read.
`timescale 1ns / 1ps

module ordered_list_append_delete_core import olad_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [LEN_W-1:0]        out_length
);

  logic      q_valid;
  logic      q_ready;
  olad_cmd_t q_cmd;

  olad_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_value    (in_value),
    .in_position (in_position),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cmd       (q_cmd)
  );

  olad_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_length     (out_length)
  );

endmodule

/* tb/ordered_list_append_delete_core_test.sv */
// Self-checking testbench for ordered_list_append_delete_core: a directed table, then random
// append, delete, read and unused-opcode words, each result checked against the table
// or a behavioral list predictor. Depends on olad_pkg and the core; needs nothing else.
`timescale 1ns / 1ps

module ordered_list_append_delete_core_test;
  import olad_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 400;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [VAL_W-1:0]    value;
    logic [POS_W-1:0]    position;
    logic [4:0]          reps;
    bit                  typed;
    status_t             status;
    logic [VAL_W-1:0]    read_value;
    logic [LEN_W-1:0]    length;
  } directed_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [OP_W-1:0]         in_opcode;
  logic signed [VAL_W-1:0] in_value;
  logic [POS_W-1:0]        in_position;
  logic                    out_valid;
  logic                    out_ready;
  logic [STATUS_W-1:0]     out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic [LEN_W-1:0]        out_length;

  logic signed [VAL_W-1:0] list_cells [CAPACITY_DEF];
  int                      list_len;
  list_result_t            pending_results [$];
  int                      mismatches;
  int                      results_seen;
  int                      cycle_count;

  directed_row_t script [21] = '{
    '{OP_READ,   32'h0000_0000, 4'd0,  5'd1,  1'b1, STAT_RANGE,    32'h0, 5'd0},
    '{OP_DELETE, 32'h0000_0005, 4'd0,  5'd1,  1'b1, STAT_EMPTY,    32'h0, 5'd0},
    '{OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 5'd1,  1'b1, STAT_OK,       32'h0, 5'd0},
    '{OP_APPEND, 32'h8000_0000, 4'd0,  5'd1,  1'b1, STAT_OK,       32'h0, 5'd1},
    '{OP_DELETE, 32'h8000_0000, 4'd0,  5'd1,  1'b1, STAT_OK,       32'h0, 5'd0},
    '{OP_READ,   32'h0000_0000, 4'd0,  5'd1,  1'b1, STAT_RANGE,    32'h0, 5'd0},
    '{OP_APPEND, 32'h7FFF_FFFF, 4'd15, 5'd1,  1'b1, STAT_OK,       32'h0, 5'd1},
    '{OP_APPEND, 32'h8000_0000, 4'd0,  5'd1,  1'b1, STAT_OK,       32'h0, 5'd2},
    '{OP_APPEND, 32'h0000_0000, 4'd0,  5'd1,  1'b0, STAT_OK,       32'h0, 5'd0},
    '{OP_APPEND, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b0, STAT_OK,       32'h0, 5'd0},
    '{OP_APPEND, 32'h7FFF_FFFF, 4'd0,  5'd1,  1'b0, STAT_OK,       32'h0, 5'd0},
    '{OP_READ,   32'h0000_0000, 4'd0,  5'd1,  1'b1, STAT_OK, 32'h7FFF_FFFF, 5'd5},
    '{OP_READ,   32'h0000_0000, 4'd15, 5'd1,  1'b1, STAT_RANGE,    32'h0, 5'd5},
    '{OP_DELETE, 32'h7FFF_FFFF, 4'd0,  5'd1,  1'b0, STAT_OK,       32'h0, 5'd0},
    '{OP_READ,   32'h0000_0000, 4'd3,  5'd1,  1'b0, STAT_OK,       32'h0, 5'd0},
    '{OP_DELETE, 32'h0001_2345, 4'd0,  5'd1,  1'b1, STAT_NOTFOUND, 32'h0, 5'd4},
    '{OP_APPEND, 32'h0000_5A5A, 4'd0,  5'd12, 1'b0, STAT_OK,       32'h0, 5'd0},
    '{OP_APPEND, 32'h0000_0001, 4'd0,  5'd1,  1'b1, STAT_FULL,     32'h0, 5'd16},
    '{OP_READ,   32'h0000_0000, 4'd15, 5'd1,  1'b1, STAT_OK, 32'h0000_5A5A, 5'd16},
    '{OP_DELETE, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b0, STAT_OK,       32'h0, 5'd0},
    '{OP_UNUSED, 32'h1234_5678, 4'd7,  5'd1,  1'b0, STAT_OK,       32'h0, 5'd0}
  };

  ordered_list_append_delete_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_length     (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic list_result_t apply_to_list(input logic [OP_W-1:0] op,
                                                 input logic signed [VAL_W-1:0] v,
                                                 input logic [POS_W-1:0] p);
    list_result_t r;
    int hit;
    r.status = STAT_OK;
    r.read_value = '0;
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY_DEF) begin
          r.status = STAT_FULL;
        end else begin
          list_cells[list_len] = v;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_cells[i] == v) hit = i;
          end
          if (hit < 0) begin
            r.status = STAT_NOTFOUND;
          end else begin
            for (int i = hit; i < list_len - 1; i++) list_cells[i] = list_cells[i + 1];
            list_len--;
          end
        end
      end
      OP_READ: begin
        if (p >= list_len) r.status = STAT_RANGE;
        else r.read_value = list_cells[p];
      end
      default: begin
      end
    endcase
    r.length = list_len[LEN_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end else if (roll < 50) begin
      return $signed(32'($urandom_range(0, 7))) - 32'sd4;
    end
    return $signed($urandom);
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v,
                           input logic [POS_W-1:0] p, input bit typed,
                           input list_result_t typed_res);
    list_result_t predicted;
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_value    <= v;
    in_position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_list(op, v, p);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic idle_gap(input bit calm);
    int n;
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) n = 0;
    else if (roll < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(6, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    list_result_t typed_res;
    logic [OP_W-1:0] op;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    int roll;
    bit calm;
    in_valid    <= 1'b0;
    in_opcode   <= OP_APPEND;
    in_value    <= '0;
    in_position <= '0;
    rst_n       <= 1'b0;
    list_len = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        typed_res = '{script[r].status, script[r].read_value, script[r].length};
        send_word(script[r].op, script[r].value, script[r].position, script[r].typed,
                  typed_res);
        idle_gap(1'b0);
      end
    end

    for (int idx = 0; idx < RANDOM_WORDS; idx++) begin
      calm = ((idx / 50) % 4) == 3;
      roll = $urandom_range(0, 99);
      // Alternate fill-heavy and drain-heavy stretches so the list hits full and empty.
      if ((idx / 32) % 2 == 0) begin
        op = (roll < 55) ? OP_APPEND : (roll < 75) ? OP_DELETE : (roll < 95) ? OP_READ
                                                                             : OP_UNUSED;
      end else begin
        op = (roll < 20) ? OP_APPEND : (roll < 70) ? OP_DELETE : (roll < 95) ? OP_READ
                                                                             : OP_UNUSED;
      end
      if (op == OP_DELETE && list_len > 0 && $urandom_range(0, 99) < 75)
        v = list_cells[$urandom_range(0, list_len - 1)];
      else
        v = random_value();
      if (list_len > 0 && $urandom_range(0, 99) < 80)
        p = POS_W'($urandom_range(0, list_len - 1));
      else
        p = POS_W'($urandom_range(0, 15));
      send_word(op, v, p, 1'b0, '0);
      if (idx == 200) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else begin
        idle_gap(calm);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int stall_left;
    int cycles;
    bit held;
    stall_left = 0;
    cycles = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= 60) begin
        // Long hold-off so the command queue fills and the input side stalls.
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
      end else begin
        cycles++;
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else if ((cycles / 200) % 3 == 0) begin
          out_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 25) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
        @(posedge clk);
      end
    end
  end

  initial begin : result_check
    list_result_t want;
    mismatches = 0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: status %0d read_value %0d length %0d",
                     out_status, out_read_value, out_length);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status || out_read_value !== want.read_value ||
              out_length !== want.length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on result %0d: expected status %0d read_value %0d length %0d, got status %0d read_value %0d length %0d",
                       results_seen, want.status, want.read_value, want.length,
                       out_status, out_read_value, out_length);
          end
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
